FILE: rtl/bfa_pkg.sv
// Bitmap frame allocator package: beat types, action and status codes,
// register indexes and fixed widths. No dependencies.
package bfa_pkg;

  localparam int CNT_W  = 17;
  localparam int ADDR_W = 32;
  localparam int IDX_W  = 2;

  localparam logic [ADDR_W-1:0] BASE_ADDR = 32'h0010_0000;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  localparam logic [IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOW_RSV     = 2'd1;
  localparam logic [IDX_W-1:0] REG_HIGH_RSV    = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] frame_address;
    logic [CNT_W-1:0]  free_count;
  } out_t;

endpackage

FILE: rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/bfa_div.sv
// Frame index split into map word and bit by a constant word width, using a
// reciprocal multiply and a multiply-back subtract. Depends on bfa_pkg.
module bfa_div #(
  parameter int DIVISOR = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfa_pkg::CNT_W-1:0]   dividend_i,
  output logic                        done_o,
  output logic [bfa_pkg::CNT_W-1:0]   quot_o,
  output logic [$clog2(DIVISOR)-1:0]  rem_o
);
  import bfa_pkg::*;

  localparam int BW = $clog2(DIVISOR);
  localparam int SH = CNT_W + BW;
  localparam int MW = CNT_W + 2;
  localparam int PW = CNT_W + MW;
  localparam longint unsigned RECIP_V =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0]    RECIP = MW'(RECIP_V);
  localparam logic [CNT_W-1:0] DIV_V = CNT_W'(DIVISOR);

  logic [CNT_W-1:0] dvd_q, quot_q, back;
  logic [BW-1:0]    rem_q;
  logic             mul_q, sub_q, done_q;
  logic [PW-1:0]    prod;

  // ceil(2^SH / DIVISOR) keeps the quotient exact for every CNT_W-bit index
  assign prod = {{MW{1'b0}}, dvd_q} * {{CNT_W{1'b0}}, RECIP};
  assign back = quot_q * DIV_V;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (mul_q) begin
      quot_q <= CNT_W'(prod >> SH);
    end
    if (sub_q) begin
      rem_q <= BW'(dvd_q - back);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/bitmap_frame_allocator.sv
// First-fit bitmap page frame allocator, top level.
// Depends on bfa_pkg, bfa_ram and bfa_div.
//
// Input beats carry an action (init, allocate, free, nop) and an address; every
// input beat yields exactly one output beat with status, allocated address
// and the free counter. Both channels use valid/stall; an input beat is
// taken only when the block is idle and its output register is empty.
// Configuration (frame count, low and high reserved frames) must be written
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle (not enforced).
// After reset a clearing pass writes zero to all MAP_WORDS map words, one
// per cycle, before the first beat is taken.
// Operation, all through the single map RAM:
//   init     writes every map word in turn (one map word written per cycle)
//   allocate reads the map words in turn and takes the first clear bit; it
//            answers no-free once the scan passes the frame count
//   free     splits the frame index into word and bit in bfa_div, reads the
//            map word and updates it; a bad address answers from idle
// One item is in flight at a time. While out_stall_i is high the result
// holds in the output register and no new beat is accepted.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES    = 65536,
  parameter int PAGE_SHIFT    = 12,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfa_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [bfa_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bfa_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bfa_pkg::out_t               out_data_o
);
  import bfa_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(MAP_WORD_BITS);
  localparam int BASE_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
  localparam int CMP_W     = (BASE_W > CNT_W ? BASE_W : CNT_W) + 1;

  localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [CMP_W-1:0]  WORD_STEP = CMP_W'(MAP_WORD_BITS);
  localparam logic [ADDR_W-1:0] MAX_FR    = ADDR_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_ARD  = 3'd3;
  localparam logic [2:0] S_AEV  = 3'd4;
  localparam logic [2:0] S_FDIV = 3'd5;
  localparam logic [2:0] S_FRD  = 3'd6;
  localparam logic [2:0] S_FCHK = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    w_q, w_d;
  logic [CMP_W-1:0] base_q, base_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] frame_count_q, low_rsv_q, high_rsv_q;
  logic [CNT_W-1:0] r_q, r_d, hlo_q, hlo_d, icnt_q, icnt_d;
  logic             hi_en_q, hi_en_d;
  out_t             out_q, res;
  logic             out_valid_q, res_set;

  logic [CNT_W-1:0] n, r_c, c_c;
  logic             accept;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, init_mask;
  logic [BW-1:0]            zidx;
  logic [CMP_W-1:0]         zframe;
  logic [ADDR_W-1:0]        alloc_addr, free_off, free_idx;

  logic             div_start, div_done;
  logic [CNT_W-1:0] div_quot;
  logic [BW-1:0]    div_rem;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    n = (ADDR_W'(frame_count_q) > MAX_FR) ? MAX_FR[CNT_W-1:0] : frame_count_q;
    r_c = (low_rsv_q > n) ? n : low_rsv_q;
    c_c = (r_c < n) ? n - r_c : '0;
    if (c_c > high_rsv_q) begin
      c_c = c_c - high_rsv_q;
    end
  end

  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      logic [CMP_W-1:0] fr;
      fr = base_q + CMP_W'(j);
      init_mask[j] = (fr < CMP_W'(r_q)) ||
                     (hi_en_q && fr >= CMP_W'(hlo_q) && fr < CMP_W'(n));
    end
  end

  always_comb begin
    zidx = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (!ram_rdata[j]) begin
        zidx = BW'(j);
      end
    end
  end

  assign zframe     = base_q + CMP_W'(zidx);
  assign alloc_addr = (ADDR_W'(zframe[CNT_W-1:0]) << PAGE_SHIFT) + BASE_ADDR;
  assign free_off   = in_data_i.address - BASE_ADDR;
  assign free_idx   = free_off >> PAGE_SHIFT;
  assign ram_raddr  = (state_q == S_FRD) ? AW'(div_quot) : w_q;

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    r_d       = r_q;
    hlo_d     = hlo_q;
    hi_en_d   = hi_en_q;
    icnt_d    = icnt_q;
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = '0;
    div_start = 1'b0;
    res_set   = 1'b0;
    res       = '{status: ST_OK, frame_address: '0, free_count: cnt_q};
    unique case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        w_d    = w_q + 1'b1;
        if (w_q == LAST_WORD) begin
          w_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          w_d    = '0;
          base_d = '0;
          unique case (action_e'(in_data_i.action))
            ACT_INIT: begin
              r_d     = r_c;
              hi_en_d = n > high_rsv_q;
              hlo_d   = n - high_rsv_q;
              icnt_d  = c_c;
              state_d = S_INIT;
            end
            ACT_ALLOC: state_d = S_ARD;
            ACT_FREE: begin
              if (in_data_i.address < BASE_ADDR || free_idx >= ADDR_W'(n)) begin
                res_set    = 1'b1;
                res.status = ST_RANGE;
              end else begin
                div_start = 1'b1;
                state_d   = S_FDIV;
              end
            end
            ACT_NOP: res_set = 1'b1;
            default: res_set = 1'b1;
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_mask;
        w_d       = w_q + 1'b1;
        base_d    = base_q + WORD_STEP;
        if (w_q == LAST_WORD) begin
          cnt_d          = icnt_q;
          res_set        = 1'b1;
          res.free_count = icnt_q;
          state_d        = S_IDLE;
        end
      end
      S_ARD: begin
        if (base_q >= CMP_W'(n)) begin
          res_set    = 1'b1;
          res.status = ST_NO_FREE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_AEV;
        end
      end
      S_AEV: begin
        if (&ram_rdata) begin
          w_d     = w_q + 1'b1;
          base_d  = base_q + WORD_STEP;
          state_d = S_ARD;
        end else begin
          res_set = 1'b1;
          state_d = S_IDLE;
          if (zframe < CMP_W'(n)) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << zidx);
            cnt_d     = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
            res.frame_address = alloc_addr;
            res.free_count    = cnt_d;
          end else begin
            res.status = ST_NO_FREE;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          state_d = S_FRD;
        end
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        res_set   = 1'b1;
        state_d   = S_IDLE;
        ram_waddr = AW'(div_quot);
        if (ram_rdata[div_rem]) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << div_rem);
          cnt_d     = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
          res.free_count = cnt_d;
        end else begin
          res.status = ST_NOT_USED;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      w_q           <= '0;
      base_q        <= '0;
      cnt_q         <= '0;
      hi_en_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      frame_count_q <= CNT_W'(65536);
      low_rsv_q     <= '0;
      high_rsv_q    <= CNT_W'(256);
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      hi_en_q <= hi_en_d;
      if (res_set) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_COUNT: frame_count_q <= cfg_data_i;
          REG_LOW_RSV:     low_rsv_q     <= cfg_data_i;
          REG_HIGH_RSV:    high_rsv_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    hlo_q  <= hlo_d;
    icnt_q <= icnt_d;
    if (res_set) begin
      out_q <= res;
    end
  end

  bfa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_div #(
    .DIVISOR (MAP_WORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (free_idx[CNT_W-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("beat accepted while an item was in flight");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !ram_we)
    else $error("map written while idle");

  a_div_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_FDIV)
    else $error("divider finished outside a free");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.frame_address == '0)
    else $error("failed beat carries an address");
`endif

endmodule
